FILE: hdl/jpi_pkg.sv
// ----------------------------------------------------------------------------
// jpi_pkg: shared types and constants of the JSON pretty indenter
// Character codes, widths, sequencer states and the emission plan that the
// decoder hands to the output sequencer.
// ----------------------------------------------------------------------------
package jpi_pkg;

  localparam int BYTE_W      = 8;
  localparam int DEPTH_W     = 4;   // nesting depth never exceeds 15
  localparam int IW_W        = 3;   // indent width register
  localparam int CNT_W       = 6;   // spaces in one run, at most 15 * 4
  localparam int ADDR_W      = 2;
  localparam int DATA_W      = 32;
  localparam int MAX_DEPTH_DEF = 15;

  localparam logic [IW_W-1:0]   WIDTH_LIMIT    = 3'd4;
  localparam logic [IW_W-1:0]   IW_RESET       = 3'd4;
  localparam logic [ADDR_W-1:0] REG_INDENT_W   = 2'd0;

  localparam logic [BYTE_W-1:0] CH_LBRACE  = 8'h7b;
  localparam logic [BYTE_W-1:0] CH_RBRACE  = 8'h7d;
  localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2c;
  localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF      = 8'h0a;
  localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7f;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_NL,
    ST_SPC,
    ST_POST
  } seq_state_t;

  // What one input transaction emits: an optional leading byte, an optional
  // newline plus a run of spaces, and an optional trailing closing brace.
  typedef struct packed {
    logic              pre_valid;
    logic [BYTE_W-1:0] pre_byte;
    logic              err;
    logic              indent;
    logic [CNT_W-1:0]  count;
    logic              post_valid;
  } plan_t;

endpackage

FILE: hdl/jpi_decode.sv
// ----------------------------------------------------------------------------
// jpi_decode: byte classifier and parse state
// Holds the quote, escape, depth and failure state, and turns each accepted
// transaction into an emission plan for the sequencer.
// ----------------------------------------------------------------------------
module jpi_decode #(
  parameter int MAX_DEPTH = jpi_pkg::MAX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [jpi_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_end_only,
  input  logic [jpi_pkg::IW_W-1:0]     indent_width,
  output jpi_pkg::plan_t               plan
);

  logic                          quotes_r, quotes_nxt;
  logic                          esc_r, esc_nxt;
  logic                          failed_r, failed_nxt;
  logic [jpi_pkg::DEPTH_W-1:0]   depth_r, depth_nxt;
  logic [jpi_pkg::IW_W-1:0]      w_eff;
  logic                          is_ws;

  assign w_eff = (indent_width > jpi_pkg::WIDTH_LIMIT) ? jpi_pkg::WIDTH_LIMIT : indent_width;
  assign is_ws = (in_byte == jpi_pkg::CH_SPACE) || (in_byte == jpi_pkg::CH_TAB) ||
                 (in_byte == jpi_pkg::CH_CR) || (in_byte == jpi_pkg::CH_LF);

  always_comb begin
    quotes_nxt      = quotes_r;
    esc_nxt         = esc_r;
    failed_nxt      = failed_r;
    depth_nxt       = depth_r;
    plan.pre_valid  = 1'b0;
    plan.pre_byte   = in_byte;
    plan.err        = 1'b0;
    plan.indent     = 1'b0;
    plan.post_valid = 1'b0;
    if (!failed_r) begin
      if (in_end_only) begin
        plan.pre_valid = 1'b1;
        plan.pre_byte  = jpi_pkg::CH_LF;
        quotes_nxt     = 1'b0;
        esc_nxt        = 1'b0;
        depth_nxt      = '0;
      end else if (esc_r) begin
        esc_nxt        = 1'b0;
        plan.pre_valid = 1'b1;
      end else if (in_byte > jpi_pkg::ASCII_MAX) begin
        failed_nxt     = 1'b1;
        plan.pre_valid = 1'b1;
        plan.pre_byte  = '0;
        plan.err       = 1'b1;
      end else if (in_byte == jpi_pkg::CH_BSLASH) begin
        esc_nxt        = 1'b1;
        plan.pre_valid = 1'b1;
      end else if (in_byte == jpi_pkg::CH_QUOTE) begin
        quotes_nxt     = ~quotes_r;
        plan.pre_valid = 1'b1;
      end else if (quotes_r) begin
        plan.pre_valid = 1'b1;
      end else if (is_ws) begin
        plan.pre_valid = 1'b0;
      end else if (in_byte == jpi_pkg::CH_LBRACE) begin
        plan.pre_valid = 1'b1;
        plan.indent    = 1'b1;
        if (depth_r < jpi_pkg::DEPTH_W'(MAX_DEPTH)) begin
          depth_nxt = depth_r + jpi_pkg::DEPTH_W'(1);
        end
      end else if (in_byte == jpi_pkg::CH_RBRACE) begin
        plan.indent     = 1'b1;
        plan.post_valid = 1'b1;
        if (depth_r != '0) begin
          depth_nxt = depth_r - jpi_pkg::DEPTH_W'(1);
        end
      end else if (in_byte == jpi_pkg::CH_COMMA) begin
        plan.pre_valid = 1'b1;
        plan.indent    = 1'b1;
      end else begin
        plan.pre_valid = 1'b1;
      end
    end
    // Indentation uses the depth after this transaction's update.
    plan.count = jpi_pkg::CNT_W'(depth_nxt) * jpi_pkg::CNT_W'(w_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quotes_r <= 1'b0;
      esc_r    <= 1'b0;
      failed_r <= 1'b0;
      depth_r  <= '0;
    end else if (accept) begin
      quotes_r <= quotes_nxt;
      esc_r    <= esc_nxt;
      failed_r <= failed_nxt;
      depth_r  <= depth_nxt;
    end
  end

endmodule

FILE: hdl/jpi_seq.sv
// ----------------------------------------------------------------------------
// jpi_seq: output sequencer
// Walks one emission plan a byte per unstalled cycle to a registered output
// stage, counting the indentation run down with a single shared counter.
// ----------------------------------------------------------------------------
module jpi_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  jpi_pkg::plan_t              plan,
  output logic                        busy,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [jpi_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last,
  output logic                        out_error
);

  jpi_pkg::seq_state_t             state_r, state_nxt;
  jpi_pkg::plan_t                  plan_r;
  logic [jpi_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                            out_valid_r;
  logic [jpi_pkg::BYTE_W-1:0]      out_byte_r;
  logic                            out_last_r;
  logic                            out_error_r;
  logic                            out_free;
  logic                            emit;
  logic [jpi_pkg::BYTE_W-1:0]      emit_byte;
  logic                            emit_last;
  logic                            emit_err;

  assign out_free = !out_valid_r || !out_stall;
  assign busy     = (state_r != jpi_pkg::ST_IDLE);

  // Output selection for the current step.
  always_comb begin
    emit      = 1'b0;
    emit_byte = jpi_pkg::CH_SPACE;
    emit_last = 1'b0;
    emit_err  = 1'b0;
    case (state_r)
      jpi_pkg::ST_PRE: begin
        emit      = 1'b1;
        emit_byte = plan_r.pre_byte;
        emit_err  = plan_r.err;
        emit_last = !plan_r.indent && !plan_r.post_valid;
      end
      jpi_pkg::ST_NL: begin
        emit      = 1'b1;
        emit_byte = jpi_pkg::CH_LF;
        emit_last = (cnt_r == '0) && !plan_r.post_valid;
      end
      jpi_pkg::ST_SPC: begin
        emit      = 1'b1;
        emit_byte = jpi_pkg::CH_SPACE;
        emit_last = (cnt_r == jpi_pkg::CNT_W'(1)) && !plan_r.post_valid;
      end
      jpi_pkg::ST_POST: begin
        emit      = 1'b1;
        emit_byte = jpi_pkg::CH_RBRACE;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Next state and the space counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      jpi_pkg::ST_IDLE: begin
        if (start) begin
          cnt_nxt = plan.count;
          if (plan.pre_valid) begin
            state_nxt = jpi_pkg::ST_PRE;
          end else if (plan.indent) begin
            state_nxt = jpi_pkg::ST_NL;
          end else if (plan.post_valid) begin
            state_nxt = jpi_pkg::ST_POST;
          end
        end
      end
      jpi_pkg::ST_PRE: begin
        if (out_free) begin
          if (plan_r.indent) begin
            state_nxt = jpi_pkg::ST_NL;
          end else if (plan_r.post_valid) begin
            state_nxt = jpi_pkg::ST_POST;
          end else begin
            state_nxt = jpi_pkg::ST_IDLE;
          end
        end
      end
      jpi_pkg::ST_NL: begin
        if (out_free) begin
          if (cnt_r != '0) begin
            state_nxt = jpi_pkg::ST_SPC;
          end else if (plan_r.post_valid) begin
            state_nxt = jpi_pkg::ST_POST;
          end else begin
            state_nxt = jpi_pkg::ST_IDLE;
          end
        end
      end
      jpi_pkg::ST_SPC: begin
        if (out_free) begin
          cnt_nxt = cnt_r - jpi_pkg::CNT_W'(1);
          if (cnt_r == jpi_pkg::CNT_W'(1)) begin
            state_nxt = plan_r.post_valid ? jpi_pkg::ST_POST : jpi_pkg::ST_IDLE;
          end
        end
      end
      jpi_pkg::ST_POST: begin
        if (out_free) begin
          state_nxt = jpi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = jpi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jpi_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_free) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (start && !busy) begin
      plan_r <= plan;
    end
    if (out_free && emit) begin
      out_byte_r  <= emit_byte;
      out_last_r  <= emit_last;
      out_error_r <= emit_err;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_error = out_error_r;

endmodule

FILE: hdl/json_pretty_indenter.sv
// ----------------------------------------------------------------------------
// json_pretty_indenter: streaming JSON reformatter
// Usage: JSON text enters one byte per transaction on the in_ channel
// (in_valid / in_stall); in_end_only marks the end of a document and carries
// no byte. Formatted bytes leave on the out_ channel (out_valid / out_stall),
// with out_last on the final byte that an input transaction produces and
// out_error on the single result that flags a non-ASCII byte.
// Timing: an accepted transaction's plan is registered in the sequencer, and
// its first result is registered once the output is free. The sequencer emits
// one byte per cycle unless the output stalls; in_stall is high until a
// transaction's last result is registered. Whitespace outside strings gives no
// result. A brace or comma costs its byte, a newline and depth * indent_width
// spaces (at most 62 results), all counted out by one space counter.
// A receiver stall freezes the output register and the sequencer; input is
// taken again once the last result sits in the output register.
// Reset (rst_n low, synchronous) clears the parse state, the error flag and
// the output stage, and sets indent_width to 4. After an error result all
// input is swallowed until reset. Write indent_width at APB byte address 0
// only while idle; the block does not enforce this. Values above 4 act as 4.
// ----------------------------------------------------------------------------
module json_pretty_indenter #(
  parameter int MAX_DEPTH = jpi_pkg::MAX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [jpi_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_end_only,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [jpi_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_last,
  output logic                         out_error,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jpi_pkg::ADDR_W-1:0]   paddr,
  input  logic [jpi_pkg::DATA_W-1:0]   pwdata,
  output logic [jpi_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [jpi_pkg::IW_W-1:0] indent_width_r;
  logic                     accept;
  logic                     busy;
  jpi_pkg::plan_t           plan;

  assign pready = 1'b1;
  assign prdata = (paddr == jpi_pkg::REG_INDENT_W) ?
                  jpi_pkg::DATA_W'(indent_width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      indent_width_r <= jpi_pkg::IW_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == jpi_pkg::REG_INDENT_W)) begin
      indent_width_r <= pwdata[jpi_pkg::IW_W-1:0];
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  jpi_decode #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_byte      (in_byte),
    .in_end_only  (in_end_only),
    .indent_width (indent_width_r),
    .plan         (plan)
  );

  jpi_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .plan      (plan),
    .busy      (busy),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_error (out_error)
  );

endmodule

FILE: hdl/jpi_checker.sv
// ----------------------------------------------------------------------------
// jpi_checker: port-level checks for the JSON pretty indenter
// Watches the output channel for error signaling and stall behavior.
// ----------------------------------------------------------------------------
module jpi_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [jpi_pkg::BYTE_W-1:0]  out_byte,
  input logic                        out_last,
  input logic                        out_error
);

  // An error result carries a zero byte.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_byte == '0))
    else $error("error result with nonzero byte");

  // An error result is always the last of its transaction.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> out_last)
    else $error("error result without last");

  // Once the error is delivered, the stream stays silent.
  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_error) |=> !out_valid)
    else $error("output after error result");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind json_pretty_indenter jpi_checker u_jpi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_last  (out_last),
  .out_error (out_error)
);
